// ===== rtl/sbpr_pkg.sv =====
// Shared types and constants for the servo bus packet receiver.
package sbpr_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned WORD_W     = 16;
  localparam int unsigned KIND_W     = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned HEAD_DEPTH = 4;
  localparam int unsigned HEAD_IDX_W = 2;
  localparam int unsigned QDEPTH     = 2;
  localparam int unsigned QPTR_W     = 1;
  localparam int unsigned QCNT_W     = 2;

  localparam logic [BYTE_W-1:0] MARKER_BYTE     = 8'hFF;
  localparam logic [BYTE_W-1:0] WORD_WRITE_LEN  = 8'd5;

  localparam logic [BYTE_W-1:0] OWN_ID_RST      = 8'd1;
  localparam logic [BYTE_W-1:0] BCAST_ID_RST    = 8'd254;
  localparam logic [BYTE_W-1:0] READ_OP_RST     = 8'd2;
  localparam logic [BYTE_W-1:0] WRITE_OP_RST    = 8'd3;

  typedef enum logic [KIND_W-1:0] {
    KIND_HDR_OK     = 3'd0,
    KIND_HDR_BAD    = 3'd1,
    KIND_CSUM_ERR   = 3'd2,
    KIND_READ       = 3'd3,
    KIND_BYTE_WRITE = 3'd4,
    KIND_WORD_WRITE = 3'd5
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OWN_ID   = 2'd0,
    REG_BCAST_ID = 2'd1,
    REG_READ_OP  = 2'd2,
    REG_WRITE_OP = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    EV_HDR_OK   = 2'd0,
    EV_HDR_BAD  = 2'd1,
    EV_CSUM_ERR = 2'd2,
    EV_PACKET   = 2'd3
  } event_t;

  typedef struct packed {
    logic [BYTE_W-1:0] own_id;
    logic [BYTE_W-1:0] bcast_id;
    logic [BYTE_W-1:0] read_opcode;
    logic [BYTE_W-1:0] write_opcode;
  } cfg_t;

  typedef struct packed {
    event_t                               ev;
    logic                                 is_word;
    logic [HEAD_DEPTH-1:0][BYTE_W-1:0]    head;
  } qentry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

// ===== rtl/sbpr_in_if.sv =====
// Received byte channel interface.
interface sbpr_in_if;
  logic                           valid;
  logic                           ready;
  logic [sbpr_pkg::BYTE_W-1:0]    rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/sbpr_out_if.sv =====
// Decoded result channel interface.
interface sbpr_out_if;
  logic                           valid;
  logic                           ready;
  logic [sbpr_pkg::KIND_W-1:0]    kind;
  logic [sbpr_pkg::BYTE_W-1:0]    reg_address;
  logic [sbpr_pkg::WORD_W-1:0]    write_data;
  logic [sbpr_pkg::BYTE_W-1:0]    read_count;

  modport source (output valid, output kind, output reg_address, output write_data,
                  output read_count, input ready);
  modport sink   (input valid, input kind, input reg_address, input write_data,
                  input read_count, output ready);
endinterface

// ===== rtl/sbpr_front.sv =====
// Byte framing front end: header, id, length and checksum tracking.
module sbpr_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic [sbpr_pkg::BYTE_W-1:0]   rx_byte,
  input  sbpr_pkg::cfg_t                cfg,
  output logic                          push,
  output sbpr_pkg::qentry_t             entry
);

  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_ID   = 3'd2,
    PH_LEN  = 3'd3,
    PH_BODY = 3'd4
  } phase_t;

  phase_t                                                   phase_r, phase_nxt;
  logic                                                     fwm_r, fwm_nxt;
  logic [sbpr_pkg::BYTE_W-1:0]                              pid_r, pid_nxt;
  logic [sbpr_pkg::BYTE_W-1:0]                              len_r, len_nxt;
  logic [sbpr_pkg::BYTE_W-1:0]                              seen_r, seen_nxt;
  logic [sbpr_pkg::BYTE_W-1:0]                              sum_r, sum_nxt;
  logic [sbpr_pkg::HEAD_DEPTH-1:0][sbpr_pkg::BYTE_W-1:0]    head_r, head_nxt;
  logic                                                     ev_push;
  logic                                                     hdr_ok;

  always_comb begin
    phase_nxt     = phase_r;
    fwm_nxt       = fwm_r;
    pid_nxt       = pid_r;
    len_nxt       = len_r;
    seen_nxt      = seen_r;
    sum_nxt       = sum_r;
    head_nxt      = head_r;
    ev_push       = 1'b0;
    entry         = '0;
    hdr_ok        = fwm_r && (rx_byte == sbpr_pkg::MARKER_BYTE);
    case (phase_r)
      PH_HDR1: begin
        ev_push   = 1'b1;
        entry.ev  = hdr_ok ? sbpr_pkg::EV_HDR_OK : sbpr_pkg::EV_HDR_BAD;
        phase_nxt = hdr_ok ? PH_ID : PH_HDR0;
      end
      PH_ID: begin
        pid_nxt   = rx_byte;
        phase_nxt = (rx_byte == cfg.own_id || rx_byte == cfg.bcast_id) ? PH_LEN : PH_HDR0;
      end
      PH_LEN: begin
        len_nxt  = rx_byte;
        seen_nxt = '0;
        sum_nxt  = pid_r + rx_byte;
        head_nxt = '0;
        if (rx_byte == '0) begin
          ev_push   = 1'b1;
          entry.ev  = sbpr_pkg::EV_CSUM_ERR;
          phase_nxt = PH_HDR0;
        end else begin
          phase_nxt = PH_BODY;
        end
      end
      PH_BODY: begin
        if (seen_r < sbpr_pkg::BYTE_W'(sbpr_pkg::HEAD_DEPTH)) begin
          head_nxt[seen_r[sbpr_pkg::HEAD_IDX_W-1:0]] = rx_byte;
        end
        if (({1'b0, seen_r} + 9'd1) < {1'b0, len_r}) begin
          sum_nxt  = sum_r + rx_byte;
          seen_nxt = seen_r + 8'd1;
        end else begin
          phase_nxt     = PH_HDR0;
          ev_push       = 1'b1;
          entry.ev      = (~sum_r != rx_byte) ? sbpr_pkg::EV_CSUM_ERR : sbpr_pkg::EV_PACKET;
          entry.is_word = (len_r == sbpr_pkg::WORD_WRITE_LEN);
          entry.head    = head_nxt;
        end
      end
      default: begin
        fwm_nxt   = (rx_byte == sbpr_pkg::MARKER_BYTE);
        phase_nxt = PH_HDR1;
      end
    endcase
  end

  assign push = accept && ev_push;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HDR0;
      fwm_r   <= 1'b0;
      pid_r   <= '0;
      len_r   <= '0;
      seen_r  <= '0;
      sum_r   <= '0;
      head_r  <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      fwm_r   <= fwm_nxt;
      pid_r   <= pid_nxt;
      len_r   <= len_nxt;
      seen_r  <= seen_nxt;
      sum_r   <= sum_nxt;
      head_r  <= head_nxt;
    end
  end

endmodule

// ===== rtl/sbpr_queue.sv =====
// Two-entry queue between the framing front end and the result back end.
module sbpr_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  sbpr_pkg::qentry_t   din,
  input  logic                pop,
  output sbpr_pkg::qentry_t   dout,
  output sbpr_pkg::qstat_t    stat
);

  sbpr_pkg::qentry_t                  mem [sbpr_pkg::QDEPTH];
  logic [sbpr_pkg::QPTR_W-1:0]        wr_ptr_r;
  logic [sbpr_pkg::QPTR_W-1:0]        rd_ptr_r;
  logic [sbpr_pkg::QCNT_W-1:0]        cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == sbpr_pkg::QCNT_W'(sbpr_pkg::QDEPTH));
  assign stat.empty = (cnt_r == '0);
  assign dout       = mem[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/sbpr_back.sv =====
// Result back end: instruction decode and output register.
module sbpr_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sbpr_pkg::qstat_t              qstat,
  input  sbpr_pkg::qentry_t             entry,
  input  sbpr_pkg::cfg_t                cfg,
  input  logic                          out_ready,
  output logic                          pop,
  output logic                          out_valid,
  output logic [sbpr_pkg::KIND_W-1:0]   out_kind,
  output logic [sbpr_pkg::BYTE_W-1:0]   out_reg_address,
  output logic [sbpr_pkg::WORD_W-1:0]   out_write_data,
  output logic [sbpr_pkg::BYTE_W-1:0]   out_read_count
);

  logic                           valid_r;
  sbpr_pkg::kind_t                kind_r, kind_nxt;
  logic [sbpr_pkg::BYTE_W-1:0]    addr_r, addr_nxt;
  logic [sbpr_pkg::WORD_W-1:0]    data_r, data_nxt;
  logic [sbpr_pkg::BYTE_W-1:0]    cnt_r, cnt_nxt;
  logic                           has_res;

  assign pop = !qstat.empty && (!valid_r || out_ready);

  always_comb begin
    has_res  = 1'b1;
    kind_nxt = sbpr_pkg::KIND_HDR_OK;
    addr_nxt = '0;
    data_nxt = '0;
    cnt_nxt  = '0;
    case (entry.ev)
      sbpr_pkg::EV_HDR_OK:   kind_nxt = sbpr_pkg::KIND_HDR_OK;
      sbpr_pkg::EV_HDR_BAD:  kind_nxt = sbpr_pkg::KIND_HDR_BAD;
      sbpr_pkg::EV_CSUM_ERR: kind_nxt = sbpr_pkg::KIND_CSUM_ERR;
      sbpr_pkg::EV_PACKET: begin
        if (entry.head[0] == cfg.read_opcode) begin
          kind_nxt = sbpr_pkg::KIND_READ;
          addr_nxt = entry.head[1];
          cnt_nxt  = entry.head[2];
        end else if (entry.head[0] == cfg.write_opcode) begin
          addr_nxt = entry.head[1];
          if (entry.is_word) begin
            kind_nxt = sbpr_pkg::KIND_WORD_WRITE;
            data_nxt = {entry.head[3], entry.head[2]};
          end else begin
            kind_nxt = sbpr_pkg::KIND_BYTE_WRITE;
            data_nxt = {8'd0, entry.head[2]};
          end
        end else begin
          has_res = 1'b0;
        end
      end
      default: has_res = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= has_res;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kind_r <= kind_nxt;
      addr_r <= addr_nxt;
      data_r <= data_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  assign out_valid       = valid_r;
  assign out_kind        = kind_r;
  assign out_reg_address = addr_r;
  assign out_write_data  = data_r;
  assign out_read_count  = cnt_r;

endmodule

// ===== rtl/servo_bus_packet_receiver_core.sv =====
// Servo bus packet receiver top level: config registers, front end, queue, back end.
//
// Bytes from a serial receiver enter on in_ch (valid/ready, field rx_byte), one
// transaction per byte. Results leave on out_ch (valid/ready, fields kind,
// reg_address, write_data, read_count), at most one per byte: header ok or bad
// for each header pair, checksum error, read, byte write or word write.
// The configuration port (cfg_we, cfg_index, cfg_wdata) sets own id, broadcast id
// and the read and write opcodes; write it only while the block is idle.
// Throughput: one byte per cycle while the queue is not full. The framing state
// machine updates at the edge that takes a byte and queues any result there;
// decode reads the queue head and loads the output register when the entry is
// popped, and out_ch then shows that registered result.
// A two-entry queue sits between framing and decode; when out_ch stalls, the
// output register holds, the queue fills and in_ch.ready drops once it is full.
// Reset (rst_n low, synchronous) restores the register defaults (own id 1,
// broadcast id 254, read opcode 2, write opcode 3), empties the queue and
// returns framing to waiting for the first header byte.
module servo_bus_packet_receiver_core (
  input  logic                              clk,
  input  logic                              rst_n,
  sbpr_in_if.sink                           in_ch,
  sbpr_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [sbpr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sbpr_pkg::BYTE_W-1:0]       cfg_wdata
);

  sbpr_pkg::cfg_t      cfg_r;
  sbpr_pkg::qentry_t   q_din;
  sbpr_pkg::qentry_t   q_dout;
  sbpr_pkg::qstat_t    q_stat;
  logic                q_push;
  logic                q_pop;
  logic                in_accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.own_id       <= sbpr_pkg::OWN_ID_RST;
      cfg_r.bcast_id     <= sbpr_pkg::BCAST_ID_RST;
      cfg_r.read_opcode  <= sbpr_pkg::READ_OP_RST;
      cfg_r.write_opcode <= sbpr_pkg::WRITE_OP_RST;
    end else if (cfg_we) begin
      case (sbpr_pkg::cfg_reg_t'(cfg_index))
        sbpr_pkg::REG_OWN_ID:   cfg_r.own_id       <= cfg_wdata;
        sbpr_pkg::REG_BCAST_ID: cfg_r.bcast_id     <= cfg_wdata;
        sbpr_pkg::REG_READ_OP:  cfg_r.read_opcode  <= cfg_wdata;
        sbpr_pkg::REG_WRITE_OP: cfg_r.write_opcode <= cfg_wdata;
        default:                cfg_r              <= cfg_r;
      endcase
    end
  end

  assign in_ch.ready = !q_stat.full;
  assign in_accept   = in_ch.valid && in_ch.ready;

  sbpr_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_accept),
    .rx_byte (in_ch.rx_byte),
    .cfg     (cfg_r),
    .push    (q_push),
    .entry   (q_din)
  );

  sbpr_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .stat  (q_stat)
  );

  sbpr_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .qstat           (q_stat),
    .entry           (q_dout),
    .cfg             (cfg_r),
    .out_ready       (out_ch.ready),
    .pop             (q_pop),
    .out_valid       (out_ch.valid),
    .out_kind        (out_ch.kind),
    .out_reg_address (out_ch.reg_address),
    .out_write_data  (out_ch.write_data),
    .out_read_count  (out_ch.read_count)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("queue push while full");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("queue pop while empty");

  a_result_from_pop: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(q_pop))
    else $error("result appeared without a queue pop");

  a_count_only_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.kind != sbpr_pkg::KIND_READ) |-> (out_ch.read_count == '0))
    else $error("read count set on a non-read result");

endmodule
